### rtl/core/rcc_pkg.sv
// shared constants, types and sine table for the column ray caster
package rcc_pkg;

    // geometry and march limits
    localparam int MAP_SIDE      = 16;
    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;
    localparam int MAX_STEPS     = 400;
    localparam int STEP_Q8       = 13;

    localparam int MAP_BITS  = $clog2(MAP_SIDE);
    localparam int MAP_CELLS = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W    = 2 * MAP_BITS;

    // port widths
    localparam int POS_W      = 12;
    localparam int ANG_W      = 10;
    localparam int FOV_W      = 9;
    localparam int COL_W      = 10;
    localparam int IDX_W      = 8;
    localparam int CELL_W     = 3;
    localparam int TOP_W      = 8;
    localparam int HT_W       = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // column to angle offset: fov * column / SCREEN_WIDTH by reciprocal
    localparam int PROD_W   = FOV_W + COL_W;
    localparam int RECIP_SH = 29;
    localparam int RECIP_W  = 30;
    localparam int MUL_W    = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / SCREEN_WIDTH);
    localparam logic [PROD_W-1:0]  SW_P  = PROD_W'(SCREEN_WIDTH);

    // march datapath
    localparam int FRAC   = 22;
    localparam int TRIG_W = 16;
    localparam int K_W    = $clog2(MAX_STEPS + 1);
    localparam int P_W    = $clog2(STEP_Q8 * MAX_STEPS + 1);
    localparam int PX_W   = $clog2((1 << 26) + 16384 * STEP_Q8 * MAX_STEPS) + 1;
    localparam int CW     = PX_W - FRAC;

    // distance and height division
    localparam int DIST_W = P_W + 1 + TRIG_W;
    localparam int Q_W    = $clog2(SCREEN_HEIGHT + 1);
    localparam int CMP_W  = DIST_W + Q_W;
    localparam int CNT_W  = $clog2(Q_W);
    localparam logic [CMP_W-1:0] DIV_NUM = CMP_W'(SCREEN_HEIGHT) << FRAC;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FOV   = 2'd3;

    localparam logic [POS_W-1:0] POS_X_RST = 12'd282;
    localparam logic [POS_W-1:0] POS_Y_RST = 12'd1792;
    localparam logic [ANG_W-1:0] VIEW_RST  = 10'd0;
    localparam logic [FOV_W-1:0] FOV_RST   = 9'd142;

    // item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CAST  = 1'b1;

    typedef longint unsigned t_u64;
    typedef logic [14:0] t_sine_tab [0:256];

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic prod;
        logic recip;
        logic ang;
        logic trig;
        logic march;
        logic corr;
        logic div_start;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic march_done;
        logic div_done;
        logic out_free;
    } t_dp_stat;

    // shift-subtract division for the table build
    function automatic t_u64 f_udiv(input t_u64 num, input t_u64 den);
        t_u64 quo;
        t_u64 rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // quarter-wave sine in q1.14 from an 11th order taylor sum in q30
    function automatic t_sine_tab f_build_sine();
        t_sine_tab tab;
        t_u64      x;
        t_u64      term;
        t_u64      q;
        longint    sum;
        for (int i = 0; i <= 256; i++) begin
            x    = (t_u64'(i) * 64'd3373259426 + 64'd256) >> 9;
            sum  = longint'(x);
            term = x;
            for (int n = 1; n <= 5; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = f_udiv(term, t_u64'((2 * n) * (2 * n + 1)));
                if ((n & 1) == 1) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            q = (t_u64'(sum) + 64'd32768) >> 16;
            if (q > 64'd16384) q = 64'd16384;
            tab[i] = 15'(q);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = f_build_sine();

    // full-turn sine by quadrant mirroring
    function automatic logic signed [TRIG_W-1:0] f_sin(input logic [ANG_W-1:0] a);
        logic [7:0]        r;
        logic [8:0]        rm;
        logic [TRIG_W-1:0] v;
        r  = a[7:0];
        rm = 9'd256 - {1'b0, r};
        case (a[9:8])
            2'd0:    v = {1'b0, SINE_TAB[r]};
            2'd1:    v = {1'b0, SINE_TAB[rm]};
            2'd2:    v = -{1'b0, SINE_TAB[r]};
            default: v = -{1'b0, SINE_TAB[rm]};
        endcase
        return $signed(v);
    endfunction

    function automatic logic signed [TRIG_W-1:0] f_cos(input logic [ANG_W-1:0] a);
        return f_sin(a + ANG_W'(256));
    endfunction

endpackage

### rtl/core/rcc_ram.sv
// generic single write port ram with registered read
module rcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/rcc_div.sv
// iterative restoring divider for wall height, saturating at screen height
module rcc_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [rcc_pkg::DIST_W-1:0] i_den,
    output logic                              o_done,
    output logic [rcc_pkg::HT_W-1:0]          o_height
);

    logic [rcc_pkg::CMP_W-1:0] den_ext;
    logic                      sat;
    logic [rcc_pkg::CMP_W-1:0] r_rem;
    logic [rcc_pkg::CMP_W-1:0] r_dsh;
    logic [rcc_pkg::Q_W-1:0]   r_q;
    logic [rcc_pkg::CNT_W-1:0] r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic                      ge;

    // nonpositive distance or quotient past the saturation range
    assign den_ext = {{rcc_pkg::Q_W{1'b0}}, i_den};
    assign sat     = (i_den <= 0) || (rcc_pkg::DIV_NUM >= (den_ext << rcc_pkg::Q_W));
    assign ge      = r_rem >= r_dsh;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !sat;
                r_done <= sat;
                r_cnt  <= rcc_pkg::CNT_W'(rcc_pkg::Q_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= rcc_pkg::DIV_NUM;
            r_dsh <= den_ext << (rcc_pkg::Q_W - 1);
            r_q   <= sat ? rcc_pkg::Q_W'(rcc_pkg::SCREEN_HEIGHT) : '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[rcc_pkg::Q_W-2:0], ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done   = r_done;
    assign o_height = (r_q > rcc_pkg::Q_W'(rcc_pkg::SCREEN_HEIGHT))
                    ? rcc_pkg::HT_W'(rcc_pkg::SCREEN_HEIGHT) : rcc_pkg::HT_W'(r_q);

endmodule

### rtl/core/rcc_dp.sv
// datapath: config registers, tile map, angle setup, march, distance, result register
module rcc_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rcc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rcc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_kind,
    input  logic [rcc_pkg::IDX_W-1:0]       i_cell_index,
    input  logic [rcc_pkg::CELL_W-1:0]      i_cell_value,
    input  logic [rcc_pkg::COL_W-1:0]       i_column,
    input  rcc_pkg::t_dp_cmd                i_cmd,
    output rcc_pkg::t_dp_stat               o_stat,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic [rcc_pkg::COL_W-1:0]       o_column_out,
    output logic [rcc_pkg::TOP_W-1:0]       o_wall_top,
    output logic [rcc_pkg::HT_W-1:0]        o_strip_rows,
    output logic [rcc_pkg::CELL_W-1:0]      o_wall_kind
);

    logic [rcc_pkg::POS_W-1:0]  r_pos_x;
    logic [rcc_pkg::POS_W-1:0]  r_pos_y;
    logic [rcc_pkg::ANG_W-1:0]  r_view;
    logic [rcc_pkg::FOV_W-1:0]  r_fov;

    logic                        wr_en;
    logic [rcc_pkg::ADDR_W-1:0]  waddr;
    logic [rcc_pkg::ADDR_W-1:0]  raddr;
    logic [rcc_pkg::CELL_W-1:0]  ram_q;
    logic [rcc_pkg::MAP_CELLS-1:0] r_cell_vld;

    logic [rcc_pkg::COL_W-1:0]  r_column;
    logic [rcc_pkg::PROD_W-1:0] r_prod;
    logic [rcc_pkg::PROD_W-1:0] r_qest;
    logic [rcc_pkg::PROD_W-1:0] rem;
    logic [rcc_pkg::PROD_W-1:0] offs;
    logic [rcc_pkg::ANG_W-1:0]  half;
    logic [rcc_pkg::ANG_W-1:0]  r_ray;
    logic [rcc_pkg::ANG_W-1:0]  r_rel;

    logic signed [rcc_pkg::TRIG_W-1:0] cr;
    logic signed [rcc_pkg::TRIG_W-1:0] sr;
    logic signed [rcc_pkg::TRIG_W-1:0] r_crel;
    logic signed [rcc_pkg::PX_W-1:0]   r_dx;
    logic signed [rcc_pkg::PX_W-1:0]   r_dy;
    logic signed [rcc_pkg::PX_W-1:0]   r_px;
    logic signed [rcc_pkg::PX_W-1:0]   r_py;
    logic [rcc_pkg::K_W-1:0]           r_k;
    logic [rcc_pkg::P_W-1:0]           r_pk;

    logic [rcc_pkg::CW-1:0]     cx;
    logic [rcc_pkg::CW-1:0]     cy;
    logic                        in_map;
    logic                        issue;
    logic                        hit;
    logic                        march_done;
    logic                        r_b_vld;
    logic                        r_b_inmap;
    logic                        r_b_cvld;
    logic [rcc_pkg::P_W-1:0]     r_b_pk;
    logic [rcc_pkg::P_W-1:0]     r_p;
    logic [rcc_pkg::CELL_W-1:0]  r_kind;

    logic signed [rcc_pkg::DIST_W-1:0] r_dist;
    logic                        div_done;
    logic [rcc_pkg::HT_W-1:0]    div_height;

    logic                        r_out_vld;
    logic [rcc_pkg::COL_W-1:0]   r_column_out;
    logic [rcc_pkg::TOP_W-1:0]   r_top;
    logic [rcc_pkg::HT_W-1:0]    r_height;
    logic [rcc_pkg::CELL_W-1:0]  r_kind_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= rcc_pkg::POS_X_RST;
            r_pos_y <= rcc_pkg::POS_Y_RST;
            r_view  <= rcc_pkg::VIEW_RST;
            r_fov   <= rcc_pkg::FOV_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rcc_pkg::CFG_POS_X: r_pos_x <= i_cfg_data[rcc_pkg::POS_W-1:0];
                rcc_pkg::CFG_POS_Y: r_pos_y <= i_cfg_data[rcc_pkg::POS_W-1:0];
                rcc_pkg::CFG_VIEW:  r_view  <= i_cfg_data[rcc_pkg::ANG_W-1:0];
                rcc_pkg::CFG_FOV:   r_fov   <= i_cfg_data[rcc_pkg::FOV_W-1:0];
                default: ;
            endcase
        end
    end

    // tile map writes, out-of-range indexes dropped
    assign wr_en = i_cmd.accept && (i_kind == rcc_pkg::KIND_WRITE)
                && (32'(i_cell_index) < rcc_pkg::MAP_CELLS);
    assign waddr = rcc_pkg::ADDR_W'(i_cell_index);

    rcc_ram #(
        .WIDTH (rcc_pkg::CELL_W),
        .DEPTH (rcc_pkg::MAP_CELLS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (waddr),
        .i_wdata (i_cell_value),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    // per-cell written flags, an unwritten cell reads as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_vld <= '0;
        end else if (wr_en) begin
            r_cell_vld[waddr] <= 1'b1;
        end
    end

    // column capture and angle setup
    assign rem  = r_prod - r_qest * rcc_pkg::SW_P;
    assign offs = (rem >= rcc_pkg::SW_P) ? r_qest + 1'b1 : r_qest;
    assign half = rcc_pkg::ANG_W'(r_fov >> 1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_kind == rcc_pkg::KIND_CAST)) begin
            r_column <= i_column;
        end
        if (i_cmd.prod) begin
            r_prod <= rcc_pkg::PROD_W'(r_fov) * rcc_pkg::PROD_W'(r_column);
        end
        if (i_cmd.recip) begin
            r_qest <= rcc_pkg::PROD_W'((rcc_pkg::MUL_W'(r_prod) * rcc_pkg::MUL_W'(rcc_pkg::RECIP))
                      >> rcc_pkg::RECIP_SH);
        end
        if (i_cmd.ang) begin
            r_ray <= r_view - half + rcc_pkg::ANG_W'(offs);
            r_rel <= rcc_pkg::ANG_W'(offs) - half;
        end
    end

    // trig lookup and march start
    assign cr = rcc_pkg::f_cos(r_ray);
    assign sr = rcc_pkg::f_sin(r_ray);

    // march stage a: cell of current point, stage b: map data check
    assign cx     = r_px[rcc_pkg::PX_W-1:rcc_pkg::FRAC];
    assign cy     = r_py[rcc_pkg::PX_W-1:rcc_pkg::FRAC];
    assign in_map = !cx[rcc_pkg::CW-1] && (cx < rcc_pkg::CW'(rcc_pkg::MAP_SIDE))
                 && !cy[rcc_pkg::CW-1] && (cy < rcc_pkg::CW'(rcc_pkg::MAP_SIDE));
    assign raddr  = {cy[rcc_pkg::MAP_BITS-1:0], cx[rcc_pkg::MAP_BITS-1:0]};
    assign issue  = r_k < rcc_pkg::K_W'(rcc_pkg::MAX_STEPS);
    assign hit    = r_b_vld && r_b_inmap && r_b_cvld && (ram_q != '0);
    assign march_done = hit || (!issue && !r_b_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_cmd.trig) begin
            r_b_vld <= 1'b0;
        end else if (i_cmd.march) begin
            r_b_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.trig) begin
            r_dx   <= rcc_pkg::PX_W'(cr) * rcc_pkg::PX_W'(rcc_pkg::STEP_Q8);
            r_dy   <= rcc_pkg::PX_W'(sr) * rcc_pkg::PX_W'(rcc_pkg::STEP_Q8);
            r_px   <= rcc_pkg::PX_W'({r_pos_x, 14'd0});
            r_py   <= rcc_pkg::PX_W'({r_pos_y, 14'd0});
            r_crel <= rcc_pkg::f_cos(r_rel);
            r_k    <= '0;
            r_pk   <= '0;
        end else if (i_cmd.march) begin
            if (issue) begin
                r_k       <= r_k + 1'b1;
                r_pk      <= r_pk + rcc_pkg::P_W'(rcc_pkg::STEP_Q8);
                r_px      <= r_px + r_dx;
                r_py      <= r_py + r_dy;
                r_b_inmap <= in_map;
                r_b_pk    <= r_pk;
                r_b_cvld  <= r_cell_vld[raddr];
            end
            if (march_done) begin
                r_p    <= hit ? r_b_pk : rcc_pkg::P_W'(rcc_pkg::STEP_Q8 * rcc_pkg::MAX_STEPS);
                r_kind <= hit ? ram_q : '0;
            end
        end
    end

    // corrected distance
    always_ff @(posedge i_clk) begin
        if (i_cmd.corr) begin
            r_dist <= rcc_pkg::DIST_W'($signed({1'b0, r_p})) * rcc_pkg::DIST_W'(r_crel);
        end
    end

    rcc_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.div_start),
        .i_den    (r_dist),
        .o_done   (div_done),
        .o_height (div_height)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_column_out <= r_column;
            r_height     <= div_height;
            r_top        <= rcc_pkg::TOP_W'(
                                (rcc_pkg::HT_W'(rcc_pkg::SCREEN_HEIGHT) - div_height) >> 1);
            r_kind_out   <= r_kind;
        end
    end

    assign o_stat.march_done = march_done;
    assign o_stat.div_done   = div_done;
    assign o_stat.out_free   = !r_out_vld || !i_out_stall;

    assign o_out_valid   = r_out_vld;
    assign o_column_out  = r_column_out;
    assign o_wall_top    = r_top;
    assign o_strip_rows  = r_height;
    assign o_wall_kind   = r_kind_out;

endmodule

### rtl/core/rcc_ctrl.sv
// controller state machine sequencing one item at a time
module rcc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_kind,
    output logic              o_in_stall,
    output rcc_pkg::t_dp_cmd  o_cmd,
    input  rcc_pkg::t_dp_stat i_stat
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PROD  = 4'd1;
    localparam logic [3:0] S_RECIP = 4'd2;
    localparam logic [3:0] S_ANG   = 4'd3;
    localparam logic [3:0] S_TRIG  = 4'd4;
    localparam logic [3:0] S_MARCH = 4'd5;
    localparam logic [3:0] S_DIST  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_WAIT  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_kind == rcc_pkg::KIND_CAST) n_state = S_PROD;
                end
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = S_RECIP;
            end
            S_RECIP: begin
                o_cmd.recip = 1'b1;
                n_state     = S_ANG;
            end
            S_ANG: begin
                o_cmd.ang = 1'b1;
                n_state   = S_TRIG;
            end
            S_TRIG: begin
                o_cmd.trig = 1'b1;
                n_state    = S_MARCH;
            end
            S_MARCH: begin
                o_cmd.march = 1'b1;
                if (i_stat.march_done) n_state = S_DIST;
            end
            S_DIST: begin
                o_cmd.corr = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

`ifndef SYNTHESIS
    // an accepted cast beat blocks the input on the next cycle
    a_cast_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_kind == rcc_pkg::KIND_CAST) |=> o_in_stall)
        else $error("cast beat did not start a cast");

    // result load only when the result register can take it
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_stat.out_free)
        else $error("result register overwritten");

    // divider finishes only while it is awaited
    a_div_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == S_WAIT))
        else $error("divider done outside wait");
`endif

endmodule

### rtl/core/raymarch_column_caster.sv
// top level of the column ray caster: controller plus datapath
//
// channel  dir  handshake                 beat fields
// in       in   i_in_valid / o_in_stall   i_kind i_cell_index i_cell_value i_column
// out      out  o_out_valid / i_out_stall o_column_out o_wall_top o_strip_rows o_wall_kind
// cfg      in   i_cfg_we                  i_cfg_index i_cfg_data
//
// a map write beat is taken in idle; a cast beat runs the states prod, recip, ang, trig,
// march, dist, div, wait and out; the divider skips its iterations if the height saturates;
// a march stops at a hit or after MAX_STEPS steps; the input reopens when the result loads
// the march issues one map read per cycle, the height divider yields one bit per cycle
// reset is synchronous, active low, and clears the map at once through per-cell flags
// a waiting result does not block the next beat until its own result is ready
module raymarch_column_caster (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rcc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_kind,
    input  logic [rcc_pkg::IDX_W-1:0]      i_cell_index,
    input  logic [rcc_pkg::CELL_W-1:0]     i_cell_value,
    input  logic [rcc_pkg::COL_W-1:0]      i_column,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [rcc_pkg::COL_W-1:0]      o_column_out,
    output logic [rcc_pkg::TOP_W-1:0]      o_wall_top,
    output logic [rcc_pkg::HT_W-1:0]       o_strip_rows,
    output logic [rcc_pkg::CELL_W-1:0]     o_wall_kind
);

    rcc_pkg::t_dp_cmd  cmd;
    rcc_pkg::t_dp_stat stat;

    // sequencing
    rcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // arithmetic, map and result register
    rcc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_kind        (i_kind),
        .i_cell_index  (i_cell_index),
        .i_cell_value  (i_cell_value),
        .i_column      (i_column),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_column_out  (o_column_out),
        .o_wall_top    (o_wall_top),
        .o_strip_rows  (o_strip_rows),
        .o_wall_kind   (o_wall_kind)
    );

endmodule

### test/raymarch_column_caster_tb.sv
// testbench for the column ray caster: map writes, casts and configuration changes against a predictor
module raymarch_column_caster_tb;

    typedef struct {
        logic                         kind;
        logic [rcc_pkg::IDX_W-1:0]    cell_index;
        logic [rcc_pkg::CELL_W-1:0]   cell_value;
        logic [rcc_pkg::COL_W-1:0]    column;
    } t_beat;

    typedef struct {
        logic [rcc_pkg::COL_W-1:0]  column_out;
        logic [rcc_pkg::TOP_W-1:0]  wall_top;
        logic [rcc_pkg::HT_W-1:0]   strip_rows;
        logic [rcc_pkg::CELL_W-1:0] wall_kind;
    } t_strip;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [rcc_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [rcc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_kind = 1'b0;
    logic [rcc_pkg::IDX_W-1:0] i_cell_index = '0;
    logic [rcc_pkg::CELL_W-1:0] i_cell_value = '0;
    logic [rcc_pkg::COL_W-1:0] i_column = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [rcc_pkg::COL_W-1:0] o_column_out;
    logic [rcc_pkg::TOP_W-1:0] o_wall_top;
    logic [rcc_pkg::HT_W-1:0] o_strip_rows;
    logic [rcc_pkg::CELL_W-1:0] o_wall_kind;

    raymarch_column_caster dut (.*);

    // predictor state
    logic [rcc_pkg::CELL_W-1:0] map_model [0:rcc_pkg::MAP_CELLS-1];
    logic [rcc_pkg::POS_W-1:0] px_m = rcc_pkg::POS_X_RST;
    logic [rcc_pkg::POS_W-1:0] py_m = rcc_pkg::POS_Y_RST;
    logic [rcc_pkg::ANG_W-1:0] view_m = rcc_pkg::VIEW_RST;
    logic [rcc_pkg::FOV_W-1:0] fov_m = rcc_pkg::FOV_RST;

    t_beat  pending_beats [$];
    t_strip strips_due [$];
    int     mismatches = 0;
    longint cycles = 0;
    bit     hold_long = 1'b0;
    int     burst_left = 0;
    int     gap_left = 0;

    initial forever #1 i_clk = ~i_clk;

    // quarter-wave sine table, built the same way as the scheme defines it
    int sine_q14 [0:256];
    function automatic void build_sine_q14();
        rcc_pkg::t_u64 x, term, q;
        longint sum;
        for (int i = 0; i <= 256; i++) begin
            x = (rcc_pkg::t_u64'(i) * 64'd3373259426 + 64'd256) / 64'd512;
            sum = longint'(x);
            term = x;
            for (int n = 1; n <= 5; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / rcc_pkg::t_u64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) sum -= longint'(term);
                else sum += longint'(term);
            end
            if (sum < 0) sum = 0;
            q = (rcc_pkg::t_u64'(sum) + 64'd32768) >> 16;
            if (q > 16384) q = 16384;
            sine_q14[i] = int'(q);
        end
    endfunction

    function automatic int sin_turn(int a);
        int r, quad;
        a = a & 1023;
        r = a & 255;
        quad = a >> 8;
        case (quad)
            0: return sine_q14[r];
            1: return sine_q14[256 - r];
            2: return -sine_q14[r];
            default: return -sine_q14[256 - r];
        endcase
    endfunction

    function automatic int cell_coord(longint v);
        if (v < 0) return -1;
        if ((v >> 22) >= rcc_pkg::MAP_SIDE) return -1;
        return int'(v >> 22);
    endfunction

    // march one column over the modeled map
    function automatic t_strip cast_column(logic [rcc_pkg::COL_W-1:0] col);
        t_strip s;
        int half, offs, ray, rel, cr, sr, crel, p, hit, cx, cy, pk, height;
        longint bx, by, dist_q;
        half = int'(fov_m) >> 1;
        offs = (int'(fov_m) * int'(col)) / rcc_pkg::SCREEN_WIDTH;
        ray = (int'(view_m) + 1024 - half + offs) & 1023;
        rel = (offs + 1024 - half) & 1023;
        cr = sin_turn(ray + 256);
        sr = sin_turn(ray);
        crel = sin_turn(rel + 256);
        bx = longint'(px_m) << 14;
        by = longint'(py_m) << 14;
        p = rcc_pkg::STEP_Q8 * rcc_pkg::MAX_STEPS;
        hit = 0;
        for (int k = 0; k < rcc_pkg::MAX_STEPS; k++) begin
            pk = rcc_pkg::STEP_Q8 * k;
            cx = cell_coord(bx + longint'(cr) * pk);
            cy = cell_coord(by + longint'(sr) * pk);
            if (cx >= 0 && cy >= 0 && map_model[cy * rcc_pkg::MAP_SIDE + cx] != 0) begin
                hit = map_model[cy * rcc_pkg::MAP_SIDE + cx];
                p = pk;
                break;
            end
        end
        dist_q = longint'(p) * crel;
        if (dist_q <= 0) height = rcc_pkg::SCREEN_HEIGHT;
        else begin
            dist_q = (longint'(rcc_pkg::SCREEN_HEIGHT) << 22) / dist_q;
            height = (dist_q > rcc_pkg::SCREEN_HEIGHT) ? rcc_pkg::SCREEN_HEIGHT : int'(dist_q);
        end
        s.column_out = col;
        s.strip_rows = rcc_pkg::HT_W'(height);
        s.wall_top = rcc_pkg::TOP_W'((rcc_pkg::SCREEN_HEIGHT - height) / 2);
        s.wall_kind = rcc_pkg::CELL_W'(hit);
        return s;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // driver: bursts and gaps, payload held while stalled
    always @(posedge i_clk) begin
        t_beat b;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                b = pending_beats.pop_front();
                if (b.kind == rcc_pkg::KIND_WRITE) map_model[b.cell_index] = b.cell_value;
                else strips_due.push_back(cast_column(b.column));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_kind <= pending_beats[0].kind;
                    i_cell_index <= pending_beats[0].cell_index;
                    i_cell_value <= pending_beats[0].cell_value;
                    i_column <= pending_beats[0].column;
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 30);
                    end
                end else i_in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge i_clk) begin
        t_strip w;
        cycles++;
        if (cycles > 64'd8000000) begin
            $display("Regression FAIL");
            $finish;
        end
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (strips_due.size() == 0) begin
                    report("unexpected strip column", o_column_out, -1);
                end else begin
                    w = strips_due.pop_front();
                    if (o_column_out !== w.column_out)
                        report("column_out", o_column_out, w.column_out);
                    if (o_wall_top !== w.wall_top) report("wall_top", o_wall_top, w.wall_top);
                    if (o_strip_rows !== w.strip_rows)
                        report("strip_rows", o_strip_rows, w.strip_rows);
                    if (o_wall_kind !== w.wall_kind)
                        report("wall_kind", o_wall_kind, w.wall_kind);
                end
            end
            if (hold_long) i_out_stall <= 1'b1;
            else if ((cycles / 2000) % 3 == 0) i_out_stall <= 1'b0;
            else i_out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // long receiver hold-off counted here
    initial begin
        wait (cycles == 20000);
        hold_long = 1'b1;
        repeat (6000) @(posedge i_clk);
        hold_long = 1'b0;
    end

    task automatic add_write(int idx, int val);
        t_beat b;
        b.kind = rcc_pkg::KIND_WRITE;
        b.cell_index = rcc_pkg::IDX_W'(idx);
        b.cell_value = rcc_pkg::CELL_W'(val);
        b.column = rcc_pkg::COL_W'($urandom);
        pending_beats.push_back(b);
    endtask

    task automatic add_cast(int col);
        t_beat b;
        b.kind = rcc_pkg::KIND_CAST;
        b.cell_index = rcc_pkg::IDX_W'($urandom);
        b.cell_value = rcc_pkg::CELL_W'($urandom);
        b.column = rcc_pkg::COL_W'(col);
        pending_beats.push_back(b);
    endtask

    task automatic drain();
        wait (pending_beats.size() == 0 && !i_in_valid && strips_due.size() == 0);
        repeat (500) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [rcc_pkg::CFG_IDX_W-1:0] idx, int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= rcc_pkg::CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            rcc_pkg::CFG_POS_X: px_m = rcc_pkg::POS_W'(val);
            rcc_pkg::CFG_POS_Y: py_m = rcc_pkg::POS_W'(val);
            rcc_pkg::CFG_VIEW:  view_m = rcc_pkg::ANG_W'(val);
            default:            fov_m = rcc_pkg::FOV_W'(val);
        endcase
    endtask

    task automatic random_phase(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            if (r < 3) add_write($urandom_range(0, 255), $urandom_range(0, 7));
            else if (r < 9) add_cast($urandom_range(0, 639));
            else add_cast($urandom_range(0, 1023));
        end
    endtask

    initial begin
        for (int i = 0; i < rcc_pkg::MAP_CELLS; i++) map_model[i] = '0;
        build_sine_q14();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty map miss, border walls, column extremes
        add_cast(0);
        for (int i = 0; i < rcc_pkg::MAP_SIDE; i++) begin
            add_write(i, 1);
            add_write(i * rcc_pkg::MAP_SIDE + 15, 7);
        end
        add_write(255, 0);
        add_cast(0);
        add_cast(639);
        add_cast(320);
        add_cast(1023);
        drain();

        // random map contents and casts under several settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    set_reg(rcc_pkg::CFG_POS_X, 0);
                    set_reg(rcc_pkg::CFG_POS_Y, 0);
                    set_reg(rcc_pkg::CFG_VIEW, 0);
                    set_reg(rcc_pkg::CFG_FOV, 0);
                end
                1: begin
                    set_reg(rcc_pkg::CFG_POS_X, 4095);
                    set_reg(rcc_pkg::CFG_POS_Y, 4095);
                    set_reg(rcc_pkg::CFG_VIEW, 1023);
                    set_reg(rcc_pkg::CFG_FOV, 511);
                end
                default: begin
                    set_reg(rcc_pkg::CFG_POS_X, $urandom_range(256, 3839));
                    set_reg(rcc_pkg::CFG_POS_Y, $urandom_range(256, 3839));
                    set_reg(rcc_pkg::CFG_VIEW, $urandom_range(0, 1023));
                    set_reg(rcc_pkg::CFG_FOV, $urandom_range(0, 511));
                end
            endcase
            random_phase(ph < 2 ? 120 : 270);
            drain();
        end
        if (mismatches == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
